// ===== hw/rtl/uvtg_pkg.sv =====
// ----------------------------------------------------------------------------
// UUID version 1 generator package
// Widths, constants and register indexes shared by the generator files.
// ----------------------------------------------------------------------------
`default_nettype none

package uvtg_pkg;

  // Field widths
  localparam int unsigned TimeW  = 42;
  localparam int unsigned AdjW   = 4;
  localparam int unsigned SeqW   = 14;
  localparam int unsigned NodeW  = 48;
  localparam int unsigned TickW  = 14;
  localparam int unsigned ProdW  = TimeW + TickW;
  localparam int unsigned TsW    = 60;
  localparam int unsigned HalfW  = 64;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDataW = NodeW;

  // Timestamp constants: 100 ns ticks per millisecond, Gregorian epoch offset
  localparam logic [TickW-1:0] TicksPerMs     = 14'd10000;
  localparam logic [TsW-1:0]   GregorianOffset = 60'h1B21DD213814000;

  // Version and variant codes
  localparam logic [3:0] UuidVersion = 4'h1;
  localparam logic [1:0] UuidVariant = 2'b10;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_NODE_ID  = 1'b0,
    CFG_INIT_SEQ = 1'b1
  } cfg_idx_e;

endpackage

`default_nettype wire

// ===== hw/rtl/uvtg_if.sv =====
// ----------------------------------------------------------------------------
// UUID generator channel interfaces
// Request channel carrying the millisecond time and response channel
// carrying the UUID halves and the retry flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface uvtg_req_if;
  logic                       valid;
  logic                       ready;
  logic [uvtg_pkg::TimeW-1:0] time_ms;

  modport source (output valid, output time_ms, input ready);
  modport sink   (input valid, input time_ms, output ready);
endinterface

interface uvtg_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [uvtg_pkg::HalfW-1:0] uuid_upper;
  logic [uvtg_pkg::HalfW-1:0] uuid_lower;
  logic                       retry;

  modport source (output valid, output uuid_upper, output uuid_lower, output retry,
                  input ready);
  modport sink   (input valid, input uuid_upper, input uuid_lower, input retry,
                  output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/uuid_v1_timestamp_generator.sv =====
// ----------------------------------------------------------------------------
// UUID version 1 timestamp generator
// Turns each millisecond time request into one version 1 UUID or a retry flag.
// ----------------------------------------------------------------------------
// Usage:
//   req_i carries time_ms; rsp_o returns uuid_upper, uuid_lower and retry.
//   A transaction completes when valid and ready are both high at a clock edge.
//   The configuration port writes node_id (index 0) and initial_clock_seq
//   (index 1); write them while no request is in flight.
// Path: a request is accepted into the input register with the time-by-ticks
//   product, then moves on to the result register, where the state update
//   and the timestamp add happen, once that register is free.
// Throughput: one request per cycle while rsp_o.ready stays high; the state
//   compare, increment and timestamp add run combinationally between them.
// Stall: when the receiver holds ready low the result register keeps its
//   response, the input register fills, and req_i.ready drops; nothing is
//   lost. Reset empties both registers, clears the state and the
//   configuration; the first request after reset loads the clock sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module uuid_v1_timestamp_generator #(
  parameter int unsigned MAX_ADJUST = 10
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [uvtg_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [uvtg_pkg::CfgDataW-1:0]   cfg_wdata_i,
  uvtg_req_if.sink                             req_i,
  uvtg_rsp_if.source                           rsp_o
);

  localparam logic [uvtg_pkg::AdjW-1:0] AdjLimit = uvtg_pkg::AdjW'(MAX_ADJUST);

  // Configuration registers
  logic [uvtg_pkg::NodeW-1:0] node_id_q;
  logic [uvtg_pkg::SeqW-1:0]  init_seq_q;

  // Input register
  logic                       in_valid_q;
  logic [uvtg_pkg::TimeW-1:0] in_time_q;
  logic [uvtg_pkg::ProdW-1:0] in_prod_q;

  // Generator state
  logic                       started_q;
  logic [uvtg_pkg::TimeW-1:0] last_time_q, last_time_d;
  logic [uvtg_pkg::AdjW-1:0]  adj_q, adj_d;
  logic [uvtg_pkg::SeqW-1:0]  seq_q, seq_d;

  // Result register
  logic                       out_valid_q;
  logic [uvtg_pkg::HalfW-1:0] upper_q, upper_d;
  logic [uvtg_pkg::HalfW-1:0] lower_q, lower_d;
  logic                       retry_q, retry_d;

  logic                       advance;
  logic                       in_ready;
  logic                       step;
  logic                       same_ms;
  logic                       back_ms;
  logic [uvtg_pkg::TsW-1:0]   ts;

  // Handshake: the result register frees when empty or taken
  assign advance  = !out_valid_q || rsp_o.ready;
  assign in_ready = !in_valid_q || advance;
  assign step     = in_valid_q && advance;

  assign req_i.ready      = in_ready;
  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.uuid_upper = upper_q;
  assign rsp_o.uuid_lower = lower_q;
  assign rsp_o.retry      = retry_q;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q  <= '0;
      init_seq_q <= '0;
    end else if (cfg_we_i) begin
      case (uvtg_pkg::cfg_idx_e'(cfg_idx_i))
        uvtg_pkg::CFG_NODE_ID:  node_id_q  <= cfg_wdata_i;
        uvtg_pkg::CFG_INIT_SEQ: init_seq_q <= cfg_wdata_i[uvtg_pkg::SeqW-1:0];
        default: ;
      endcase
    end
  end

  // Capture the request and its time-by-ticks product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready && req_i.valid) begin
      in_time_q <= req_i.time_ms;
      in_prod_q <= uvtg_pkg::ProdW'(req_i.time_ms) * uvtg_pkg::ProdW'(uvtg_pkg::TicksPerMs);
    end
  end

  // Compare against the last time and pick the next state
  assign same_ms = started_q && (in_time_q == last_time_q);
  assign back_ms = started_q && (in_time_q < last_time_q);

  always_comb begin
    last_time_d = in_time_q;
    adj_d       = '0;
    seq_d       = seq_q;
    retry_d     = 1'b0;
    if (!started_q) begin
      seq_d = init_seq_q;
    end else if (back_ms) begin
      seq_d = seq_q + uvtg_pkg::SeqW'(1);
    end else if (same_ms) begin
      last_time_d = last_time_q;
      if (adj_q >= AdjLimit) begin
        retry_d = 1'b1;
        adj_d   = adj_q;
      end else begin
        adj_d = adj_q + uvtg_pkg::AdjW'(1);
      end
    end
  end

  // Build the timestamp and pack the UUID halves
  assign ts = uvtg_pkg::TsW'(in_prod_q) + uvtg_pkg::TsW'(adj_d) + uvtg_pkg::GregorianOffset;

  always_comb begin
    if (retry_d) begin
      upper_d = '0;
      lower_d = '0;
    end else begin
      upper_d = {ts[31:0], ts[47:32], uvtg_pkg::UuidVersion, ts[59:48]};
      lower_d = {uvtg_pkg::UuidVariant, seq_d, node_id_q};
    end
  end

  // Advance state when a request that is not a retry moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q   <= 1'b0;
      last_time_q <= '0;
      adj_q       <= '0;
      seq_q       <= '0;
    end else if (step && !retry_d) begin
      started_q   <= 1'b1;
      last_time_q <= last_time_d;
      adj_q       <= adj_d;
      seq_q       <= seq_d;
    end
  end

  // Hold the response until the receiver takes it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      upper_q <= upper_d;
      lower_q <= lower_d;
      retry_q <= retry_d;
    end
  end

endmodule

`default_nettype wire
